[hdl/mbgs_pkg.sv]
// Package for the masked bilinear grid sampler.
// Holds the grid cell type, the item action codes and the register indexes.
// No dependencies.
package mbgs_pkg;

  typedef struct packed {
    logic        valid;
    logic [15:0] depth;
  } cell_t;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LON_ORIGIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LAT_ORIGIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LON_CPD = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LAT_CPD = 3'd5;

  // Scaled coordinates carry this many fractional bits after the multiply.
  localparam int PROD_FRAC = 39;

endpackage

[hdl/mbgs_if.sv]
// Channel interfaces of the masked bilinear grid sampler.
// Input items, result items and configuration writes; depends on mbgs_pkg.
interface mbgs_in_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic [15:0]        cell_index;
  logic [15:0]        cell_depth;
  logic               cell_valid;
  logic signed [31:0] query_lat;
  logic signed [31:0] query_lon;
  modport source (output valid, action, cell_index, cell_depth, cell_valid,
                  query_lat, query_lon, input ready);
  modport sink (input valid, action, cell_index, cell_depth, cell_valid,
                query_lat, query_lon, output ready);
endinterface

interface mbgs_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] depth;
  logic        depth_valid;
  modport source (output valid, depth, depth_valid, input ready);
  modport sink (input valid, depth, depth_valid, output ready);
endinterface

interface mbgs_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [mbgs_pkg::CFG_IDX_W-1:0]     index;
  logic [31:0]                        data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[hdl/mbgs_cell_ram.sv]
// Grid cell memory: two copies written together, each with two read ports.
// Read data is registered and held while rd_en is low; depends on mbgs_pkg.
module mbgs_cell_ram #(
  parameter int DEPTH = 65536,
  parameter int AW    = 16
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [AW-1:0]              wr_addr,
  input  mbgs_pkg::cell_t            wr_data,
  input  logic                       rd_en,
  input  logic [3:0][AW-1:0]         rd_addr,
  output mbgs_pkg::cell_t [3:0]      rd_data
);
  import mbgs_pkg::*;

  cell_t mem_a [DEPTH];
  cell_t mem_b [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_a[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_b[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data[0] <= mem_a[rd_addr[0]];
      rd_data[1] <= mem_a[rd_addr[1]];
      rd_data[2] <= mem_b[rd_addr[2]];
      rd_data[3] <= mem_b[rd_addr[3]];
    end
  end

endmodule

[hdl/masked_bilinear_grid_sampler_top.sv]
// Masked bilinear grid sampler, top level: eight-stage query pipeline.
// Depends on mbgs_pkg, the channel interfaces and mbgs_cell_ram.
//
// The block takes one item per clock while the output is not stalled; write
// items go as far as the memory stage and update the grid in order with the
// queries around them. The pace is set by the 32 by 32 bit coordinate
// multipliers and by the registered read of the grid memory, which is kept in
// two copies so that all four neighbors of a point are read in the same cycle.
// Each stage only holds while the one after it is full and stalled, so items
// keep entering until the stages fill while a result waits at the output.
// Reset leaves the grid as is; the user must write every cell before use (unchecked).
module masked_bilinear_grid_sampler_top #(
  parameter int MAX_CELLS = 65536,
  parameter int FRAC_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  mbgs_in_if.sink       in_ch,
  mbgs_out_if.source    out_ch,
  mbgs_cfg_if.sink      cfg_ch
);
  import mbgs_pkg::*;

  localparam int AW   = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam int TW   = FRAC_BITS;
  localparam int WW   = TW + 1;
  localparam int SW   = 16 + WW;
  localparam int ACW  = SW + WW + 1;

  logic [8:0]         grid_cols;
  logic [8:0]         grid_rows;
  logic signed [31:0] lon_origin;
  logic signed [31:0] lat_origin;
  logic [31:0]        lon_cpd;
  logic [31:0]        lat_cpd;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_cols  <= 9'd2;
      grid_rows  <= 9'd2;
      lon_origin <= '0;
      lat_origin <= '0;
      lon_cpd    <= '0;
      lat_cpd    <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_GRID_COLS:  grid_cols  <= cfg_ch.data[8:0];
        REG_GRID_ROWS:  grid_rows  <= cfg_ch.data[8:0];
        REG_LON_ORIGIN: lon_origin <= cfg_ch.data;
        REG_LAT_ORIGIN: lat_origin <= cfg_ch.data;
        REG_LON_CPD:    lon_cpd    <= cfg_ch.data;
        REG_LAT_CPD:    lat_cpd    <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  logic [17:0] grid_area;
  logic        grid_ok;
  assign grid_area = 18'(grid_cols) * 18'(grid_rows);
  assign grid_ok = (grid_cols >= 9'd2) && (grid_rows >= 9'd2) &&
                   (32'(grid_area) <= 32'(MAX_CELLS)) &&
                   (lon_cpd != '0) && (lat_cpd != '0);

  // Write items ride along to the memory stage.
  logic wr1, wr2, wr3, wr4;
  logic [15:0] widx1, widx2, widx3, widx4;
  cell_t wcell1, wcell2, wcell3, wcell4;

  // Stage valids and load enables.
  logic v1, v2, v3, v4, v5, v6, v7, v8;
  logic en1, en2, en3, en4, en5, en6, en7, en8;
  logic in_fire;

  assign en8 = !v8 || out_ch.ready;
  assign en7 = !v7 || en8;
  assign en6 = !v6 || en7;
  assign en5 = !v5 || en6;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign in_ch.ready = en1;
  assign in_fire = in_ch.valid && en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0;
      v5 <= 1'b0; v6 <= 1'b0; v7 <= 1'b0; v8 <= 1'b0;
    end else begin
      if (en1) v1 <= in_fire;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4 && !wr4;
      if (en6) v6 <= v5;
      if (en7) v7 <= v6;
      if (en8) v8 <= v7;
    end
  end

  // Stage 1: offsets from the origin.
  logic signed [32:0] dlon1, dlat1;
  logic ok1;

  always_ff @(posedge clk) begin
    if (en1) begin
      wr1    <= (in_ch.action == ACT_WRITE);
      widx1  <= in_ch.cell_index;
      wcell1 <= '{valid: in_ch.cell_valid, depth: in_ch.cell_depth};
      dlon1  <= 33'(in_ch.query_lon) - 33'(lon_origin);
      dlat1  <= 33'(in_ch.query_lat) - 33'(lat_origin);
      ok1    <= grid_ok;
    end
  end

  // Stage 2: scale to fractional cell coordinates.
  logic [63:0] plon2, plat2;
  logic ok2;

  always_ff @(posedge clk) begin
    if (en2) begin
      wr2    <= wr1;
      widx2  <= widx1;
      wcell2 <= wcell1;
      plon2  <= 64'(dlon1[31:0]) * 64'(lon_cpd);
      plat2  <= 64'(dlat1[31:0]) * 64'(lat_cpd);
      ok2    <= ok1 && !dlon1[32] && !dlat1[32];
    end
  end

  // Stage 3: range check, indexes and weights.
  logic [24:0] lon_hi, lat_hi, lon_lim, lat_lim;
  logic        lon_in, lat_in;
  logic [8:0]  i0_c, j0_c, i1_c, j1_c;

  assign lon_hi  = plon2[63:PROD_FRAC];
  assign lat_hi  = plat2[63:PROD_FRAC];
  assign lon_lim = 25'(grid_cols - 9'd1);
  assign lat_lim = 25'(grid_rows - 9'd1);
  assign lon_in  = (lon_hi < lon_lim) ||
                   ((lon_hi == lon_lim) && (plon2[PROD_FRAC-1:0] == '0));
  assign lat_in  = (lat_hi < lat_lim) ||
                   ((lat_hi == lat_lim) && (plat2[PROD_FRAC-1:0] == '0));
  assign i0_c = plon2[PROD_FRAC+8:PROD_FRAC];
  assign j0_c = plat2[PROD_FRAC+8:PROD_FRAC];
  assign i1_c = (10'(i0_c) + 10'd1 < 10'(grid_cols)) ? i0_c + 9'd1 : grid_cols - 9'd1;
  assign j1_c = (10'(j0_c) + 10'd1 < 10'(grid_rows)) ? j0_c + 9'd1 : grid_rows - 9'd1;

  logic [8:0] i0_3, j0_3, i1_3, j1_3;
  logic [TW-1:0] tx3, ty3;
  logic ok3;

  always_ff @(posedge clk) begin
    if (en3) begin
      wr3    <= wr2;
      widx3  <= widx2;
      wcell3 <= wcell2;
      i0_3   <= i0_c;
      j0_3   <= j0_c;
      i1_3   <= i1_c;
      j1_3   <= j1_c;
      tx3    <= plon2[PROD_FRAC-1 -: TW];
      ty3    <= plat2[PROD_FRAC-1 -: TW];
      ok3    <= ok2 && lon_in && lat_in;
    end
  end

  // Stage 4: cell addresses.
  logic [3:0][AW-1:0] addr4;
  logic [TW-1:0] tx4, ty4;
  logic ok4;

  always_ff @(posedge clk) begin
    if (en4) begin
      wr4      <= wr3;
      widx4    <= widx3;
      wcell4   <= wcell3;
      addr4[0] <= AW'(19'(j0_3) * 19'(grid_cols) + 19'(i0_3));
      addr4[1] <= AW'(19'(j0_3) * 19'(grid_cols) + 19'(i1_3));
      addr4[2] <= AW'(19'(j1_3) * 19'(grid_cols) + 19'(i0_3));
      addr4[3] <= AW'(19'(j1_3) * 19'(grid_cols) + 19'(i1_3));
      tx4      <= tx3;
      ty4      <= ty3;
      ok4      <= ok3;
    end
  end

  // Stage 5: grid read, or the write of a write item.
  logic  wr_fire, rd_fire;
  cell_t [3:0] cell5;
  logic [TW-1:0] tx5, ty5;
  logic ok5;

  assign wr_fire = en5 && v4 && wr4 && (32'(widx4) < 32'(MAX_CELLS));
  assign rd_fire = en5 && v4 && !wr4;

  mbgs_cell_ram #(
    .DEPTH (MAX_CELLS),
    .AW    (AW)
  ) u_cell_ram (
    .clk     (clk),
    .wr_en   (wr_fire),
    .wr_addr (AW'(widx4)),
    .wr_data (wcell4),
    .rd_en   (en5),
    .rd_addr (addr4),
    .rd_data (cell5)
  );

  always_ff @(posedge clk) begin
    if (en5) begin
      tx5 <= tx4;
      ty5 <= ty4;
      ok5 <= ok4;
    end
  end

  // Stage 6: interpolate along each row.
  logic [WW-1:0] wx0, wx1;
  logic [SW-1:0] top6, bot6;
  logic [TW-1:0] ty6;
  logic ok6;

  assign wx1 = WW'(tx5);
  assign wx0 = (WW'(1) << TW) - wx1;

  always_ff @(posedge clk) begin
    if (en6) begin
      top6 <= SW'(cell5[0].depth) * SW'(wx0) + SW'(cell5[1].depth) * SW'(wx1);
      bot6 <= SW'(cell5[2].depth) * SW'(wx0) + SW'(cell5[3].depth) * SW'(wx1);
      ty6  <= ty5;
      ok6  <= ok5 && cell5[0].valid && cell5[1].valid &&
              cell5[2].valid && cell5[3].valid;
    end
  end

  // Stage 7: interpolate between rows.
  logic [WW-1:0] wy0, wy1;
  logic [ACW-1:0] acc7;
  logic ok7;

  assign wy1 = WW'(ty6);
  assign wy0 = (WW'(1) << TW) - wy1;

  always_ff @(posedge clk) begin
    if (en7) begin
      acc7 <= ACW'(top6) * ACW'(wy0) + ACW'(bot6) * ACW'(wy1);
      ok7  <= ok6;
    end
  end

  // Stage 8: round half up to Q14.2 and clamp.
  logic [ACW-1:0] rnd;
  logic [ACW-1:0] shifted;
  logic [15:0]    depth_c;

  assign rnd     = acc7 + (ACW'(1) << (2 * TW - 1));
  assign shifted = rnd >> (2 * TW);
  assign depth_c = (shifted > ACW'(16'hFFFF)) ? 16'hFFFF : shifted[15:0];

  always_ff @(posedge clk) begin
    if (en8) begin
      out_ch.depth       <= ok7 ? depth_c : 16'd0;
      out_ch.depth_valid <= ok7;
    end
  end

  assign out_ch.valid = v8;

`ifndef SYNTHESIS
  a_accept_fills_stage1: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> v1)
    else $error("accepted item did not enter the first stage");
  a_neighbors_in_grid: assert property (@(posedge clk) disable iff (rst)
    v3 && ok3 |-> (i0_3 < grid_cols) && (i1_3 < grid_cols) &&
                  (j0_3 < grid_rows) && (j1_3 < grid_rows))
    else $error("neighbor index outside the grid for an accepted point");
  a_invalid_zero_depth: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.depth_valid |-> out_ch.depth == 16'd0)
    else $error("invalid result carries a nonzero depth");
  a_write_read_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(wr_fire && rd_fire))
    else $error("grid write and read issued for the same item slot");
`endif

endmodule
